[rtl/ogr_pkg.sv]
package ogr_pkg;

  localparam int GRID_SIDE_DEF     = 128;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd6;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam int QUEUE_DEPTH   = 2;
  localparam int CORDIC_STAGES = 14;
  localparam int TRIG_W        = 18;
  localparam int ANG_W         = 17;
  localparam logic signed [TRIG_W-1:0] CORDIC_START = 18'sd19899;

  typedef struct packed {
    logic [14:0] robot_x;
    logic [14:0] robot_y;
    logic [15:0] heading;
    logic [15:0] min_range;
    logic [15:0] max_range;
    logic [7:0]  grid_cols;
    logic [7:0]  grid_rows;
  } cfg_t;

  typedef struct packed {
    logic                     func;
    logic [6:0]               col;
    logic [6:0]               row;
    logic                     occ;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Arctangent of 2^-i in binary angle units (65536 per turn).
  function automatic logic signed [ANG_W-1:0] arc_entry(input logic [3:0] i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      4'd0:    a = 17'sd8192;
      4'd1:    a = 17'sd4836;
      4'd2:    a = 17'sd2555;
      4'd3:    a = 17'sd1297;
      4'd4:    a = 17'sd651;
      4'd5:    a = 17'sd326;
      4'd6:    a = 17'sd163;
      4'd7:    a = 17'sd81;
      4'd8:    a = 17'sd41;
      4'd9:    a = 17'sd20;
      4'd10:   a = 17'sd10;
      4'd11:   a = 17'sd5;
      4'd12:   a = 17'sd3;
      4'd13:   a = 17'sd1;
      default: a = 17'sd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/ogr_ifs.sv]
interface ogr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [6:0]  cell_col;
  logic [6:0]  cell_row;
  logic        cell_occupied;
  logic [15:0] beam_angle;

  modport source (output valid, func, cell_col, cell_row, cell_occupied, beam_angle,
                  input ready);
  modport sink   (input valid, func, cell_col, cell_row, cell_occupied, beam_angle,
                  output ready);
endinterface

interface ogr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hit_range;
  logic        hit;

  modport source (output valid, hit_range, hit, input ready);
  modport sink   (input valid, hit_range, hit, output ready);
endinterface

[rtl/occupancy_grid_raycaster.sv]
// Occupancy-grid beam caster. The block keeps a GRID_SIDE x GRID_SIDE map of
// one-bit cells and answers beam queries against it. A write item (func 0)
// sets or clears one cell inside grid_cols x grid_rows and gives no result; a
// cast item (func 1) gives exactly one result: the first range, from min_range
// to max_range in half-cell steps, whose sample cell is occupied or off the
// map, or hit = 0 with range 0. After reset the map is cleared one cell per
// cycle, and no item is accepted until all GRID_SIDE*GRID_SIDE cells (16384
// at the default size) are clear; configuration writes are taken at any time.
// The front takes an item per cycle while it is idle and the command queue
// has room; a cast goes through the front's iterative CORDIC to form cos and
// sin, then the front holds the command until the queue takes it. The back
// then sets up the march, reads the map once per sample through a registered
// read, and loads the result register; a march tests up to 160 samples at
// the reset ranges and at most 512 for the widest window. The single map
// read port sets the pace of the march. Because the queue sits between the
// two, the front rotates the next beam while the back is still marching the
// last one, and the result register lets the back move on while a result
// waits.
module occupancy_grid_raycaster #(
  parameter int GRID_SIDE     = ogr_pkg::GRID_SIDE_DEF,
  parameter int FRACTION_BITS = ogr_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ogr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ogr_pkg::CFG_W-1:0]     cfg_data,
  ogr_in_if.sink                        req,
  ogr_out_if.source                     rsp
);
  import ogr_pkg::*;

  cfg_t         cfg;
  back_status_t back_status;
  cmd_t         push_cmd, pop_cmd;
  logic         push_valid, push_ready, pop_valid, pop_ready;

  // Configuration registers; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.robot_x   <= 15'd12800;
      cfg.robot_y   <= 15'd12800;
      cfg.heading   <= 16'd0;
      cfg.min_range <= 16'd128;
      cfg.max_range <= 16'd20480;
      cfg.grid_cols <= 8'd100;
      cfg.grid_rows <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROBOT_X:   cfg.robot_x   <= cfg_data[14:0];
        REG_ROBOT_Y:   cfg.robot_y   <= cfg_data[14:0];
        REG_HEADING:   cfg.heading   <= cfg_data;
        REG_MIN_RANGE: cfg.min_range <= cfg_data;
        REG_MAX_RANGE: cfg.max_range <= cfg_data;
        REG_GRID_COLS: cfg.grid_cols <= cfg_data[7:0];
        REG_GRID_ROWS: cfg.grid_rows <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front: takes items, turns a cast angle into cos and sin.
  ogr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .back_status (back_status),
    .req         (req),
    .push_valid  (push_valid),
    .push_cmd    (push_cmd),
    .push_ready  (push_ready)
  );

  // Short command queue between the two halves.
  ogr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  // Back: owns the map, applies writes and marches beams through it.
  ogr_back #(
    .GRID_SIDE     (GRID_SIDE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .status    (back_status),
    .rsp       (rsp)
  );

endmodule

[rtl/ogr_front.sv]
module ogr_front (
  input  logic               clk,
  input  logic               rst,
  input  ogr_pkg::cfg_t      cfg,
  input  ogr_pkg::back_status_t back_status,
  ogr_in_if.sink             req,
  output logic               push_valid,
  output ogr_pkg::cmd_t      push_cmd,
  input  logic               push_ready
);
  import ogr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROT  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]               state;
  logic signed [TRIG_W-1:0] x, y;
  logic signed [ANG_W-1:0]  z;
  logic [3:0]               stage;
  logic [1:0]               quad;
  logic [15:0]              angle;
  logic                     accept;
  logic signed [TRIG_W-1:0] dx, dy, c_q, s_q;

  assign req.ready = (state == ST_IDLE) && !back_status.clearing && push_ready;
  assign accept    = req.valid && req.ready;
  assign angle     = cfg.heading + req.beam_angle;
  assign dx        = y >>> stage;
  assign dy        = x >>> stage;

  always_comb begin
    unique case (quad)
      2'd0:    begin c_q = x;  s_q = y;  end
      2'd1:    begin c_q = -y; s_q = x;  end
      2'd2:    begin c_q = -x; s_q = -y; end
      default: begin c_q = y;  s_q = -x; end
    endcase
  end

  always_comb begin
    push_valid = (accept && req.func == FUNC_WRITE) || (state == ST_PUSH);
    if (state == ST_PUSH) begin
      push_cmd = '{func: FUNC_CAST, col: 7'd0, row: 7'd0, occ: 1'b0,
                   cos_v: c_q, sin_v: s_q};
    end else begin
      push_cmd = '{func: FUNC_WRITE, col: req.cell_col, row: req.cell_row,
                   occ: req.cell_occupied, cos_v: '0, sin_v: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && req.func == FUNC_CAST) begin
            x     <= CORDIC_START;
            y     <= '0;
            z     <= ANG_W'({1'b0, angle[13:0]});
            quad  <= angle[15:14];
            stage <= '0;
            state <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - arc_entry(stage);
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + arc_entry(stage);
          end
          stage <= stage + 4'd1;
          if (stage == 4'(CORDIC_STAGES - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/ogr_queue.sv]
module ogr_queue #(
  parameter int DEPTH = ogr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  ogr_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output ogr_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import ogr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = count < CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ogr_back.sv]
module ogr_back #(
  parameter int GRID_SIDE     = ogr_pkg::GRID_SIDE_DEF,
  parameter int FRACTION_BITS = ogr_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ogr_pkg::cfg_t         cfg,
  input  logic                  pop_valid,
  input  ogr_pkg::cmd_t         pop_cmd,
  output logic                  pop_ready,
  output ogr_pkg::back_status_t status,
  ogr_out_if.source             rsp
);
  import ogr_pkg::*;

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(GRID_SIDE);
  localparam int DW     = ($clog2(GRID_SIDE + 1) > 8) ? $clog2(GRID_SIDE + 1) : 8;
  localparam int RW     = 17;
  localparam int ACC_W  = 36;
  localparam int PW     = 20;
  localparam logic [RW-1:0] STEP   = RW'(1 << (FRACTION_BITS - 1));
  localparam logic [AW-1:0] SIDE_A = AW'(GRID_SIDE);
  localparam logic [DW-1:0] SIDE_D = DW'(GRID_SIDE);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MARCH  = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic                     mem [DEPTH];
  logic [AW:0]              clr_cnt;
  logic                     clearing;
  logic [1:0]               state;
  logic signed [TRIG_W-1:0] c_reg, s_reg;
  logic signed [ACC_W-1:0]  acc_x, acc_y, step_x, step_y, sh_x, sh_y;
  logic [RW-1:0]            r, r_next, r_b;
  logic                     issue_on, valid_b, oob_b, rd_data;
  logic                     res_hit, load;
  logic [15:0]              res_range;
  logic [DW-1:0]            cols, rows;
  logic signed [PW-1:0]     px, py, cx, cy;
  logic                     oob;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic                     wr_en, pop;

  assign clearing        = !clr_cnt[AW] && (clr_cnt < (AW + 1)'(DEPTH));
  assign status.clearing = clearing;
  assign cols = (DW'(cfg.grid_cols) > SIDE_D) ? SIDE_D : DW'(cfg.grid_cols);
  assign rows = (DW'(cfg.grid_rows) > SIDE_D) ? SIDE_D : DW'(cfg.grid_rows);

  assign pop_ready = (state == ST_IDLE) && !clearing;
  assign pop       = pop_valid && pop_ready;

  // Sample point of the current range, floored to a cell.
  assign sh_x   = acc_x >>> 15;
  assign sh_y   = acc_y >>> 15;
  assign px     = $signed({{(PW - 15){1'b0}}, cfg.robot_x}) + $signed(sh_x[PW-1:0]);
  assign py     = $signed({{(PW - 15){1'b0}}, cfg.robot_y}) + $signed(sh_y[PW-1:0]);
  assign cx     = px >>> FRACTION_BITS;
  assign cy     = py >>> FRACTION_BITS;
  assign oob    = cx[PW-1] || cy[PW-1]
               || (cx >= $signed({{(PW - DW){1'b0}}, cols}))
               || (cy >= $signed({{(PW - DW){1'b0}}, rows}));
  assign rd_addr = AW'(cy[CW-1:0]) * SIDE_A + AW'(cx[CW-1:0]);
  assign r_next  = r + STEP;
  assign step_x  = ACC_W'(c_reg) <<< (FRACTION_BITS - 1);
  assign step_y  = ACC_W'(s_reg) <<< (FRACTION_BITS - 1);

  assign wr_en   = pop && pop_cmd.func == FUNC_WRITE
                && (DW'(pop_cmd.col) < cols) && (DW'(pop_cmd.row) < rows);
  assign wr_addr = AW'(pop_cmd.row) * SIDE_A + AW'(pop_cmd.col);
  assign load    = (state == ST_RESULT) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[AW-1:0]] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= pop_cmd.occ;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_on  <= 1'b0;
      valid_b   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (load) begin
        rsp.valid     <= 1'b1;
        rsp.hit       <= res_hit;
        rsp.hit_range <= res_range;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (pop && pop_cmd.func == FUNC_CAST) begin
            c_reg <= pop_cmd.cos_v;
            s_reg <= pop_cmd.sin_v;
            acc_x <= $signed({2'b00, cfg.min_range}) * pop_cmd.cos_v;
            acc_y <= $signed({2'b00, cfg.min_range}) * pop_cmd.sin_v;
            r     <= {1'b0, cfg.min_range};
            valid_b <= 1'b0;
            if (cfg.min_range > cfg.max_range) begin
              res_hit   <= 1'b0;
              res_range <= '0;
              state     <= ST_RESULT;
            end else begin
              issue_on <= 1'b1;
              state    <= ST_MARCH;
            end
          end
        end
        ST_MARCH: begin
          if (valid_b && (oob_b || rd_data)) begin
            res_hit   <= 1'b1;
            res_range <= r_b[15:0];
            issue_on  <= 1'b0;
            valid_b   <= 1'b0;
            state     <= ST_RESULT;
          end else if (!issue_on) begin
            res_hit   <= 1'b0;
            res_range <= '0;
            valid_b   <= 1'b0;
            state     <= ST_RESULT;
          end else begin
            acc_x    <= acc_x + step_x;
            acc_y    <= acc_y + step_y;
            r        <= r_next;
            issue_on <= (r_next <= {1'b0, cfg.max_range});
            r_b      <= r;
            oob_b    <= oob;
            valid_b  <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == ST_IDLE && !pop_ready)
    else $error("command taken during grid clear");

  a_miss_has_zero_range: assert property (@(posedge clk) disable iff (rst)
    load && !res_hit |-> res_range == 16'd0)
    else $error("no-hit result with nonzero range");

  a_hit_in_window: assert property (@(posedge clk) disable iff (rst)
    load && res_hit |-> res_range >= cfg.min_range && res_range <= cfg.max_range)
    else $error("hit range outside the tested window");

  a_samples_ordered: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARCH && issue_on |=> r_b < r)
    else $error("sample ranges out of order");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ogr_pkg::*;

  // Index with no register behind it. A write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int MAP_SIDE = 128;
  localparam int HALF_CELL = 128;
  localparam int SETTLE_CYCLES = 700;
  localparam int HOLD_CYCLES = 900;
  localparam int ATAN_BAM [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                   10, 5, 3, 1};

  typedef struct packed {
    logic [15:0] hit_range;
    logic        hit;
  } beam_echo_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ogr_in_if  req ();
  ogr_out_if rsp ();

  occupancy_grid_raycaster i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // Shadow of the block's state: the map and the pose and window registers.
  bit          cell_map [MAP_SIDE][MAP_SIDE];
  logic [14:0] pose_x;
  logic [14:0] pose_y;
  logic [15:0] pose_yaw;
  logic [15:0] win_lo;
  logic [15:0] win_hi;
  logic [7:0]  map_cols;
  logic [7:0]  map_rows;

  beam_echo_t echo_q [$];
  int  mismatches;
  bit  calm;       // When set, neither side idles.
  bit  long_hold;  // Asks the receiver for one long stretch of backpressure.

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) begin
      return 0;
    end else if (p < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 45);
  endfunction

  // Rotation-mode CORDIC over the low 14 angle bits; the top two bits then
  // turn the vector to its quadrant. Shifts of negative values round down.
  function automatic void beam_trig(input logic [15:0] ang, output int c, output int s);
    int x;
    int y;
    int z;
    int dx;
    int dy;
    x = CORDIC_START;
    y = 0;
    z = int'(ang[13:0]);
    for (int i = 0; i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_BAM[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_BAM[i];
      end
    end
    case (ang[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // Marches the beam in half-cell steps and returns the first blocked range.
  function automatic beam_echo_t predict_beam(input logic [15:0] rel_angle);
    beam_echo_t e;
    logic [15:0] ang;
    int c;
    int s;
    int cols;
    int rows;
    longint px;
    longint py;
    longint cx;
    longint cy;
    ang = pose_yaw + rel_angle;
    beam_trig(ang, c, s);
    cols = (map_cols > MAP_SIDE) ? MAP_SIDE : int'(map_cols);
    rows = (map_rows > MAP_SIDE) ? MAP_SIDE : int'(map_rows);
    e = '0;
    for (int r = int'(win_lo); r <= int'(win_hi); r += HALF_CELL) begin
      px = longint'(pose_x) + ((longint'(r) * c) >>> 15);
      py = longint'(pose_y) + ((longint'(r) * s) >>> 15);
      cx = px >>> FRACTION_BITS_DEF;
      cy = py >>> FRACTION_BITS_DEF;
      if (cx < 0 || cy < 0 || cx >= cols || cy >= rows || cell_map[cy][cx]) begin
        e.hit_range = r[15:0];
        e.hit = 1'b1;
        return e;
      end
    end
    return e;
  endfunction

  // Offers one item and waits for the handshake. The caller is always just
  // past a rising edge, so valid gets a single assignment per time step.
  task automatic send_item(input logic fn, input logic [6:0] col, input logic [6:0] row,
                           input logic occ, input logic [15:0] ang);
    int gap;
    int cols;
    int rows;
    gap = idle_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.func          <= fn;
    req.cell_col      <= col;
    req.cell_row      <= row;
    req.cell_occupied <= occ;
    req.beam_angle    <= ang;
    do @(posedge clk); while (!req.ready);
    if (fn == FUNC_CAST) begin
      echo_q.insert(echo_q.size(), predict_beam(ang));
    end else begin
      cols = (map_cols > MAP_SIDE) ? MAP_SIDE : int'(map_cols);
      rows = (map_rows > MAP_SIDE) ? MAP_SIDE : int'(map_rows);
      if (col < cols && row < rows) begin
        cell_map[row][col] = occ;
      end
    end
  endtask

  task automatic cast(input logic [15:0] ang);
    send_item(FUNC_CAST, 7'($urandom), 7'($urandom), 1'($urandom), ang);
  endtask

  task automatic mark(input int col, input int row, input logic occ);
    send_item(FUNC_WRITE, col[6:0], row[6:0], occ, 16'($urandom));
  endtask

  // Stops offering, waits for every outstanding result, then gives a trailing
  // write item time to land in the map before anything else changes.
  task automatic settle();
    req.valid <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROBOT_X:   pose_x   = value[14:0];
      REG_ROBOT_Y:   pose_y   = value[14:0];
      REG_HEADING:   pose_yaw = value;
      REG_MIN_RANGE: win_lo   = value;
      REG_MAX_RANGE: win_hi   = value;
      REG_GRID_COLS: map_cols = value[7:0];
      REG_GRID_ROWS: map_rows = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_pose(input int x, input int y, input int yaw);
    write_reg(REG_ROBOT_X, 16'(x));
    write_reg(REG_ROBOT_Y, 16'(y));
    write_reg(REG_HEADING, 16'(yaw));
  endtask

  task automatic set_window(input int lo, input int hi);
    write_reg(REG_MIN_RANGE, 16'(lo));
    write_reg(REG_MAX_RANGE, 16'(hi));
  endtask

  task automatic set_grid(input int cols, input int rows);
    write_reg(REG_GRID_COLS, 16'(cols));
    write_reg(REG_GRID_ROWS, 16'(rows));
  endtask

  // Reset values: beams along the four axes and the top angle run out to the
  // edge of an empty 100 x 100 map.
  task automatic test_reset_state();
    cast(16'd0);
    cast(16'd16384);
    cast(16'd32768);
    cast(16'd49152);
    cast(16'hFFFF);
    settle();
  endtask

  // Cell writes at the corners, outside the grid, and a clear after a set.
  task automatic test_cell_writes();
    mark(0, 0, 1'b1);
    mark(99, 99, 1'b1);
    mark(127, 127, 1'b1);   // Outside the 100 x 100 grid, so ignored.
    mark(100, 50, 1'b1);    // Outside on the column only.
    mark(55, 50, 1'b1);     // Five cells east of the robot.
    cast(16'd0);
    cast(16'd8192);
    mark(55, 50, 1'b0);
    cast(16'd0);
    settle();
  endtask

  // Register extremes and the corner cases of the window and the grid size.
  task automatic test_register_edges();
    // Unknown index, then a cast that must still see the reset settings.
    write_reg(REG_UNUSED, 16'hFFFF);
    cast(16'd4096);
    settle();
    // Far corner of the register range, far outside the map.
    set_pose(32767, 32767, 65535);
    cast(16'd0);
    cast(16'd40000);
    settle();
    // Robot at the corner with a zero window: the only sample is the robot's own cell.
    set_pose(0, 0, 0);
    set_window(0, 0);
    cast(16'd0);
    cast(16'd32768);
    settle();
    // Empty window gives no hit.
    set_pose(12800, 12800, 0);
    set_window(300, 299);
    cast(16'd0);
    settle();
    // Full window on a saturated grid, then an empty grid.
    set_window(0, 65535);
    set_grid(255, 200);
    cast(16'd12345);
    cast(16'd0);
    settle();
    set_grid(0, 0);
    cast(16'd777);
    settle();
    set_grid(100, 100);
    set_window(128, 20480);
    settle();
  endtask

  // The receiver holds off while casts keep coming, so the block fills and
  // stalls its input. Then the sender waits for every result.
  task automatic test_backpressure();
    long_hold = 1'b1;
    repeat (16) cast(16'($urandom));
    settle();
  endtask

  // Random phases: new pose, window and grid size, then mostly short walls
  // near the robot and beams across them, with some stray writes and casts.
  task automatic test_random(input int phases, input int per_phase);
    int cols;
    int rows;
    int lo;
    int hi;
    int bx;
    int by;
    int p;
    for (int ph = 0; ph < phases; ph++) begin
      calm = (ph == 0);
      p = $urandom_range(0, 99);
      cols = (p < 6) ? 0 : (p < 12) ? $urandom_range(129, 255) : $urandom_range(20, 128);
      rows = (p < 6) ? 0 : (p < 12) ? $urandom_range(129, 255) : $urandom_range(20, 128);
      p = $urandom_range(0, 99);
      if (p < 85 && cols > 0 && rows > 0) begin
        bx = $urandom_range(0, ((cols > MAP_SIDE) ? MAP_SIDE : cols) * 256 - 1);
        by = $urandom_range(0, ((rows > MAP_SIDE) ? MAP_SIDE : rows) * 256 - 1);
      end else begin
        bx = $urandom_range(0, 32767);
        by = $urandom_range(0, 32767);
      end
      set_pose(bx, by, $urandom_range(0, 65535));
      p = $urandom_range(0, 99);
      lo = $urandom_range(0, 600);
      hi = (p < 8) ? 65535 : (p < 14) ? $urandom_range(0, lo) : $urandom_range(lo, 10000);
      if (p >= 8 && p < 14 && lo == 0) begin
        lo = 1;
        hi = 0;
      end
      set_window(lo, hi);
      set_grid(cols, rows);
      for (int n = 0; n < per_phase; n++) begin
        p = $urandom_range(0, 99);
        if (p < 45) begin
          mark((bx >> 8) + $urandom_range(0, 24) - 12, (by >> 8) + $urandom_range(0, 24) - 12,
               ($urandom_range(0, 9) < 8));
        end else if (p < 55) begin
          send_item(FUNC_WRITE, 7'($urandom), 7'($urandom), 1'($urandom), 16'($urandom));
        end else begin
          cast(16'($urandom));
        end
      end
      settle();
    end
    calm = 1'b0;
  endtask

  // Receiver: idles at random, plus one long hold when asked.
  initial begin
    rsp.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat (idle_len() + 1) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    beam_echo_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (echo_q.size() == 0) begin
        $display("%0t unexpected result: hit=%0b hit_range=%0d", $time, rsp.hit,
                 rsp.hit_range);
        mismatches++;
      end else begin
        e = echo_q.pop_front();
        if (rsp.hit !== e.hit) begin
          $display("%0t hit expected %0b actual %0b", $time, e.hit, rsp.hit);
          mismatches++;
        end
        if (rsp.hit_range !== e.hit_range) begin
          $display("%0t hit_range expected %0d actual %0d", $time, e.hit_range,
                   rsp.hit_range);
          mismatches++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run, including the map clear.
  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.func = FUNC_WRITE;
    req.cell_col = '0;
    req.cell_row = '0;
    req.cell_occupied = 1'b0;
    req.beam_angle = '0;
    mismatches = 0;
    calm = 1'b0;
    long_hold = 1'b0;
    pose_x = 15'd12800;
    pose_y = 15'd12800;
    pose_yaw = '0;
    win_lo = 16'd128;
    win_hi = 16'd20480;
    map_cols = 8'd100;
    map_rows = 8'd100;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_cell_writes();
    test_register_edges();
    test_backpressure();
    test_random(10, 115);

    // Any item a leftover result would belong to has long drained by now;
    // this catches results with no prediction behind them.
    settle();
    if (mismatches == 0 && echo_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
